/* design/smrq_pkg.sv */
// ----------------------------------------------------------------------------
// smrq_pkg
// Shared widths, command codes and cell link types for the sorted multiset
// rank query core.
// ----------------------------------------------------------------------------
package smrq_pkg;

    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 60;
    localparam int CMD_BITS   = 2;
    localparam int RANK_BITS  = 9;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = ((CNT_W > RANK_BITS) ? CNT_W : RANK_BITS) + 1;

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_BELOW  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_ABOVE  = 2'd2;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [IDX_W-1:0]      idx_t;

    // broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic above;
    } cell_ctl_t;

    // what a cell hands to its right-hand neighbour
    typedef struct packed {
        logic   valid;
        logic   gt;
        value_t value;
    } link_t;

endpackage

/* design/smrq_if.sv */
// ----------------------------------------------------------------------------
// smrq request / response channels
// Valid/ready channels carrying commands in and query results out.
// ----------------------------------------------------------------------------
interface smrq_req_if;
    logic                               valid;
    logic                               ready;
    logic [smrq_pkg::CMD_BITS-1:0]      cmd;
    logic [smrq_pkg::VALUE_BITS-1:0]    value;
    logic [smrq_pkg::RANK_BITS-1:0]     rank;

    modport source (output valid, cmd, value, rank, input ready);
    modport sink   (input valid, cmd, value, rank, output ready);
endinterface

interface smrq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               found;
    logic [smrq_pkg::VALUE_BITS-1:0]    answer;
    logic                               overflowed;

    modport source (output valid, found, answer, overflowed, input ready);
    modport sink   (input valid, found, answer, overflowed, output ready);
endinterface

/* design/smrq_cell.sv */
// ----------------------------------------------------------------------------
// smrq_cell
// One slot of the sorted row: holds a value, compares it with the operand
// and shifts right on insert when its value is greater.
// ----------------------------------------------------------------------------
module smrq_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smrq_pkg::cell_ctl_t   ctl,
    input  smrq_pkg::value_t      operand,
    input  smrq_pkg::link_t       left,
    output smrq_pkg::link_t       self,
    output logic                  qflag
);

    logic             valid_reg;
    smrq_pkg::value_t value_reg;
    logic             lt;
    logic             eq;
    logic             gt;
    logic             take;

    assign lt   = value_reg < operand;
    assign eq   = value_reg == operand;
    assign gt   = valid_reg && !lt && !eq;
    // a greater entry moves right; the first empty slot is filled
    assign take = ctl.ins_en && (gt || (!valid_reg && left.valid));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= left.gt ? left.value : operand;
        end
    end

    assign self.valid = valid_reg;
    assign self.gt    = gt;
    assign self.value = value_reg;

    // below: entry <= operand, above: entry < operand
    assign qflag = valid_reg && (lt || (!ctl.above && eq));

endmodule

/* design/smrq_chain.sv */
// ----------------------------------------------------------------------------
// smrq_chain
// The row of cells, the count of qualifying entries and the read-out of the
// selected slot.
// ----------------------------------------------------------------------------
module smrq_chain (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smrq_pkg::cell_ctl_t   ctl,
    input  smrq_pkg::value_t      operand,
    input  smrq_pkg::idx_t        sel_idx,
    output smrq_pkg::count_t      count,
    output smrq_pkg::value_t      sel_value
);

    smrq_pkg::link_t                links [smrq_pkg::CAPACITY+1];
    logic [smrq_pkg::CAPACITY-1:0]  qflag;

    assign links[0] = '{valid: 1'b1, gt: 1'b0, value: '0};

    genvar g;
    generate
        for (g = 0; g < smrq_pkg::CAPACITY; g++)
        begin : g_cell
            smrq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .operand (operand),
                .left    (links[g]),
                .self    (links[g+1]),
                .qflag   (qflag[g])
            );
        end
    endgenerate

    // qflag is a thermometer code (sorted row, valid entries first), so the
    // count is the position of the single 1-to-0 edge
    always_comb
    begin
        count = '0;
        if (&qflag)
        begin
            count = smrq_pkg::count_t'(smrq_pkg::CAPACITY);
        end
        else
        begin
            for (int i = 0; i < smrq_pkg::CAPACITY; i++)
            begin
                if (!qflag[i] && ((i == 0) || qflag[(i == 0) ? 0 : i-1]))
                begin
                    count = count | smrq_pkg::count_t'(i);
                end
            end
        end
    end

    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < smrq_pkg::CAPACITY; i++)
        begin
            if (sel_idx == smrq_pkg::idx_t'(i))
            begin
                sel_value = sel_value | links[i+1].value;
            end
        end
    end

endmodule

/* design/sorted_multiset_rank_query_core.sv */
// ----------------------------------------------------------------------------
// sorted_multiset_rank_query_core
// Sorted multiset of up to CAPACITY values with k-th below / k-th above
// queries, held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries cmd, value and rank. Insert (cmd 0) places the value
//   in sorted order and returns nothing; an insert into a full store is
//   dropped and sets the sticky overflowed flag. Query-below (cmd 1) returns
//   the rank-th largest entry <= value, query-above (cmd 2) the rank-th
//   smallest entry >= value; found is 0 and answer 0 when too few qualify.
//   Command 3 is absorbed without effect.
//   Each request takes the control sequencer through its states: an insert
//   or an unused command runs through the count state, a query through the
//   count and select states (compare and count across the row, then index
//   arithmetic and slot read-out). One request is in work at a time, so a
//   new one is taken only once the last is back in idle. A query result is
//   registered in the select step with the overflow flag as of that query.
//   The result sits in an output register; the next request is accepted
//   while it waits, and a query only stalls in its last step until the
//   receiver has taken the previous result.
//   Reset (rst_n, asynchronous) empties the store and clears the flag; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_multiset_rank_query_core (
    input  logic        clk,
    input  logic        rst_n,
    smrq_req_if.sink    req,
    smrq_rsp_if.source  rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CNT  = 2'd1;
    localparam logic [1:0] ST_SEL  = 2'd2;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    logic [smrq_pkg::CMD_BITS-1:0]     cmd_reg;
    smrq_pkg::value_t                  operand_reg;
    logic [smrq_pkg::RANK_BITS-1:0]    rank_reg;
    smrq_pkg::count_t                  qcount_reg;
    smrq_pkg::count_t                  entry_count_reg;
    logic                              overflow_reg;
    logic                              out_valid_reg;
    logic                              out_found_reg;
    smrq_pkg::value_t                  out_answer_reg;
    logic                              out_overflow_reg;

    smrq_pkg::cell_ctl_t               ctl;
    smrq_pkg::count_t                  count;
    smrq_pkg::value_t                  sel_value;
    smrq_pkg::idx_t                    sel_idx;
    logic                              accept;
    logic                              full;
    logic                              do_insert;
    logic                              do_write;
    logic                              found;
    logic [smrq_pkg::SUM_W-1:0]        kw;
    logic [smrq_pkg::SUM_W-1:0]        cw;
    logic [smrq_pkg::SUM_W-1:0]        nw;
    logic [smrq_pkg::SUM_W-1:0]        idx_full;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign full      = (entry_count_reg == smrq_pkg::count_t'(smrq_pkg::CAPACITY));
    assign do_insert = (state_reg == ST_CNT) && (cmd_reg == smrq_pkg::CMD_INSERT) && !full;
    assign do_write  = (state_reg == ST_SEL) && (!out_valid_reg || rsp.ready);

    assign ctl.ins_en = do_insert;
    assign ctl.above  = (cmd_reg == smrq_pkg::CMD_ABOVE);

    smrq_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .operand   (operand_reg),
        .sel_idx   (sel_idx),
        .count     (count),
        .sel_value (sel_value)
    );

    // rank arithmetic on the registered count
    always_comb
    begin
        kw = smrq_pkg::SUM_W'(rank_reg);
        cw = smrq_pkg::SUM_W'(qcount_reg);
        nw = smrq_pkg::SUM_W'(entry_count_reg);
        if (cmd_reg == smrq_pkg::CMD_BELOW)
        begin
            idx_full = cw - kw;
            found    = (rank_reg != '0) && (kw <= cw);
        end
        else
        begin
            idx_full = cw + kw - smrq_pkg::SUM_W'(1);
            found    = (rank_reg != '0) && (idx_full < nw);
        end
    end

    assign sel_idx = idx_full[smrq_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CNT;
                end
            end
            ST_CNT:
            begin
                if (cmd_reg == smrq_pkg::CMD_BELOW || cmd_reg == smrq_pkg::CMD_ABOVE)
                begin
                    state_next = ST_SEL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEL:
            begin
                if (do_write)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_insert)
            begin
                entry_count_reg <= entry_count_reg + smrq_pkg::count_t'(1);
            end
            if ((state_reg == ST_CNT) && (cmd_reg == smrq_pkg::CMD_INSERT) && full)
            begin
                overflow_reg <= 1'b1;
            end
            if (do_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= req.cmd;
            operand_reg <= req.value;
            rank_reg    <= req.rank;
        end
        if (state_reg == ST_CNT)
        begin
            qcount_reg <= count;
        end
        if (do_write)
        begin
            out_found_reg    <= found;
            out_answer_reg   <= found ? sel_value : '0;
            out_overflow_reg <= overflow_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.answer     = out_answer_reg;
    assign rsp.overflowed = out_overflow_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= smrq_pkg::count_t'(smrq_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.answer == '0))
        else $error("answer not zero when not found");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CNT))
        else $error("accepted request not started");

endmodule
